// ===== src/fixed_point_alu_q24_8_assert.svh =====
// Assertion macros for the Q24.8 fixed-point ALU.
// Depends on nothing; included by the top level, which carries the checks.
`ifndef FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
        else $error("check failed");
`define FPA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
`else
`define FPA_ASSERT(lbl, ck, rstn, prop)
`define FPA_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`endif
`endif

// ===== src/fpa_pkg.sv =====
// Types, constants and operation codes for the Q24.8 fixed-point ALU.
// Depends on nothing; used by every module of the block.
package fpa_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 8;
    // product bits that matter for the wrapped, rounded result
    localparam int PROD_W     = DATA_W + FRAC_BITS;
    // divide numerator |a| * 2^(F+1) + |b|
    localparam int NUM_W      = DATA_W + FRAC_BITS + 2;
    localparam int DIV_STEPS  = 7;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_PAD_W  = DIV_STAGES * DIV_STEPS;
    localparam int REM_W      = DATA_W + 1;
    localparam int NSTG       = DIV_STAGES + 3;
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        K_ADD      = 4'd0,
        K_SUB      = 4'd1,
        K_MUL      = 4'd2,
        K_DIV      = 4'd3,
        K_MIN      = 4'd4,
        K_MAX      = 4'd5,
        K_INC      = 4'd6,
        K_DEC      = 4'd7,
        K_TO_INT   = 4'd8,
        K_FROM_INT = 4'd9
    } kind_t;

    typedef struct packed {
        logic [3:0]               kind;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } op_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     a_greater;
        logic                     a_less;
        logic                     a_equal;
        logic                     divide_by_zero;
    } res_rsp_t;

    typedef struct packed {
        logic load;
        logic valid;
    } stage_ctl_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [DATA_W-1:0] simple;
        logic              gt;
        logic              lt;
        logic              eq;
        logic              neg;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
    } front_t;

    typedef struct packed {
        logic [3:0]           kind;
        logic [DATA_W-1:0]    simple;
        logic                 gt;
        logic                 lt;
        logic                 eq;
        logic                 neg;
        logic                 dz;
        logic [PROD_W-1:0]    prod;
        logic [REM_W-1:0]     rem;
        logic [REM_W-1:0]     dvs;
        logic [NUM_PAD_W-1:0] num;
    } div_t;

endpackage

// ===== src/fixed_point_alu_q24_8.sv =====
// Top level of the Q24.8 fixed-point ALU: stage chain and flow control.
// Depends on fpa_pkg, fpa_front, fpa_mul_init, fpa_div_stage, fpa_back.
//
//   channel   valid      stall      payload
//   op        op_valid   op_stall   op  (kind, operand_a, operand_b)
//   res       res_valid  res_stall  res (result_value, flags)
//
// One request enters per cycle while op_stall is low; the chain length is
// set by the restoring divider, seven quotient bits per stage.
// Each stage moves on when its successor has room, so bubbles are squeezed out.
// op_stall rises only when every stage is full and res is stalled.
// Reset clears the valid bits only.
`include "fixed_point_alu_q24_8_assert.svh"
module fixed_point_alu_q24_8
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_stall,
    input  op_req_t  op,
    output logic     res_valid,
    input  logic     res_stall,
    output res_rsp_t res
);

    logic [NSTG-1:0] vld;
    logic [NSTG-1:0] rdy;
    front_t          fdat;
    div_t            dstg [DIV_STAGES:0];

    // build the ready chain from the output back
    always_comb
    begin
        rdy[NSTG-1] = !vld[NSTG-1] || !res_stall;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !vld[k] || rdy[k+1];
    end

    assign op_stall  = !rdy[0];
    assign res_valid = vld[NSTG-1];

    fpa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{load: rdy[0], valid: op_valid}),
        .op    (op),
        .valid (vld[0]),
        .data  (fdat)
    );

    fpa_mul_init u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{load: rdy[1], valid: vld[0]}),
        .fin   (fdat),
        .valid (vld[1]),
        .data  (dstg[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        fpa_div_stage u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   ('{load: rdy[g+2], valid: vld[g+1]}),
            .din   (dstg[g]),
            .valid (vld[g+2]),
            .data  (dstg[g+1])
        );
    end

    fpa_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{load: rdy[NSTG-1], valid: vld[NSTG-2]}),
        .din   (dstg[DIV_STAGES]),
        .valid (vld[NSTG-1]),
        .rsp   (res)
    );

    // divide by zero always yields zero
    `FPA_ASSERT_IMP(a_dz_zero, clk, rst_n, res_valid && res.divide_by_zero, res.result_value == '0)
    // exactly one compare flag per result
    `FPA_ASSERT_IMP(a_flags_onehot, clk, rst_n, res_valid, $onehot({res.a_greater, res.a_less, res.a_equal}))
    // input held back only when the whole chain is full and blocked
    `FPA_ASSERT_IMP(a_stall_full, clk, rst_n, op_stall, res_valid && res_stall && (&vld))

endmodule

// ===== src/fpa_front.sv =====
// Front stage: compare flags, simple operations and operand magnitudes.
// Depends on fpa_pkg.
module fpa_front
    import fpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  op_req_t    op,
    output logic       valid,
    output front_t     data
);

    logic   valid_reg;
    front_t data_reg;
    front_t data_next;

    // work out flags, magnitudes and the simple results
    always_comb
    begin
        data_next.kind = op.kind;
        data_next.eq   = (op.operand_a == op.operand_b);
        data_next.lt   = (op.operand_a < op.operand_b);
        data_next.gt   = !data_next.eq && !data_next.lt;
        data_next.neg  = op.operand_a[DATA_W-1] ^ op.operand_b[DATA_W-1];
        data_next.ma   = op.operand_a[DATA_W-1] ? (DATA_W'(0) - op.operand_a) : op.operand_a;
        data_next.mb   = op.operand_b[DATA_W-1] ? (DATA_W'(0) - op.operand_b) : op.operand_b;
        case (op.kind)
            K_ADD:      data_next.simple = op.operand_a + op.operand_b;
            K_SUB:      data_next.simple = op.operand_a - op.operand_b;
            K_MIN:      data_next.simple = data_next.lt ? op.operand_a : op.operand_b;
            K_MAX:      data_next.simple = data_next.gt ? op.operand_a : op.operand_b;
            K_INC:      data_next.simple = op.operand_a + DATA_W'(1);
            K_DEC:      data_next.simple = op.operand_a - DATA_W'(1);
            K_TO_INT:   data_next.simple = op.operand_a >>> FRAC_BITS;
            K_FROM_INT: data_next.simple = op.operand_a << FRAC_BITS;
            default:    data_next.simple = '0;
        endcase
    end

    // hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== src/fpa_mul_init.sv =====
// Multiply stage: magnitude product and set-up of the divide numerator.
// Depends on fpa_pkg.
module fpa_mul_init
    import fpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  front_t     fin,
    output logic       valid,
    output div_t       data
);

    logic                   valid_reg;
    div_t                   data_reg;
    div_t                   data_next;
    logic [2*DATA_W-1:0]    prod_full;

    // form the product and the divide operands
    always_comb
    begin
        prod_full        = fin.ma * fin.mb;
        data_next.kind   = fin.kind;
        data_next.simple = fin.simple;
        data_next.gt     = fin.gt;
        data_next.lt     = fin.lt;
        data_next.eq     = fin.eq;
        data_next.neg    = fin.neg;
        data_next.dz     = (fin.kind == K_DIV) && (fin.mb == '0);
        data_next.prod   = prod_full[PROD_W-1:0];
        data_next.rem    = '0;
        data_next.dvs    = {fin.mb, 1'b0};
        data_next.num    = (NUM_PAD_W'(fin.ma) << (FRAC_BITS + 1)) + NUM_PAD_W'(fin.mb);
    end

    // hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== src/fpa_div_stage.sv =====
// Divide stage: DIV_STEPS restoring division steps; quotient bits shift into num.
// Depends on fpa_pkg.
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  div_t       din,
    output logic       valid,
    output div_t       data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic [REM_W:0] trial;
    logic           ge;

    // run the division steps, one quotient bit each
    always_comb
    begin
        data_next = din;
        trial     = '0;
        ge        = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial         = {data_next.rem, data_next.num[NUM_PAD_W-1]};
            ge            = (trial >= {1'b0, data_next.dvs});
            if (ge)
                trial = trial - {1'b0, data_next.dvs};
            data_next.rem = trial[REM_W-1:0];
            data_next.num = {data_next.num[NUM_PAD_W-2:0], ge};
        end
    end

    // hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    // advance the payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== src/fpa_back.sv =====
// Output stage: rounding, sign and result selection into the output register.
// Depends on fpa_pkg.
module fpa_back
    import fpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  div_t       din,
    output logic       valid,
    output res_rsp_t   rsp
);

    logic              valid_reg;
    res_rsp_t          rsp_reg;
    res_rsp_t          rsp_next;
    logic [PROD_W-1:0] rounded;
    logic [DATA_W-1:0] mag;

    // round the product, pick the magnitude and apply the sign
    always_comb
    begin
        rounded = din.prod + HALF_LSB;
        mag     = (din.kind == K_MUL) ? rounded[PROD_W-1:FRAC_BITS] : din.num[DATA_W-1:0];
        rsp_next.a_greater      = din.gt;
        rsp_next.a_less         = din.lt;
        rsp_next.a_equal        = din.eq;
        rsp_next.divide_by_zero = din.dz;
        case (din.kind)
            K_MUL:   rsp_next.result_value = (mag ^ {DATA_W{din.neg}}) + DATA_W'(din.neg);
            K_DIV:
            begin
                if (din.dz)
                    rsp_next.result_value = '0;
                else
                    rsp_next.result_value = (mag ^ {DATA_W{din.neg}}) + DATA_W'(din.neg);
            end
            default: rsp_next.result_value = din.simple;
        endcase
    end

    // hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    // advance the result
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            rsp_reg <= rsp_next;
    end

    assign valid = valid_reg;
    assign rsp   = rsp_reg;

endmodule
